// ===== src/tfec_pkg.sv =====
// Shared types, constants and helper functions for the three-floor elevator controller.
package tfec_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int POS_W       = 13;
    localparam int F0_W        = 12;
    localparam int SPACING_W   = 11;
    localparam int TOL_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    localparam logic [F0_W-1:0]      F0_RST      = 12'd0;
    localparam logic [SPACING_W-1:0] SPACING_RST = 11'd288;
    localparam logic [TOL_W-1:0]     TOL_RST     = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_FLOOR0  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd2;

    localparam logic [1:0] ACT_KEY    = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_TIMER  = 2'd2;

    localparam logic [2:0] KEY_FLOOR0 = 3'd0;
    localparam logic [2:0] KEY_FLOOR2 = 3'd2;
    localparam logic [2:0] KEY_ALARM  = 3'd3;
    localparam logic [2:0] KEY_ESTOP  = 3'd4;

    localparam logic [1:0] FLOOR_0 = 2'd0;
    localparam logic [1:0] FLOOR_1 = 2'd1;
    localparam logic [1:0] FLOOR_2 = 2'd2;

    localparam logic [6:0] SEG_0 = 7'h3F;
    localparam logic [6:0] SEG_1 = 7'h06;
    localparam logic [6:0] SEG_2 = 7'h5B;

    typedef struct packed {
        logic [F0_W-1:0]      floor0;
        logic [SPACING_W-1:0] spacing;
        logic [TOL_W-1:0]     tol;
    } cfg_t;

    typedef struct packed {
        logic       report_alarm;
        logic       report_emergency;
        logic [1:0] report_floor;
        logic       report_valid;
        logic [6:0] segments;
        logic       buzzer;
        logic       stop_lamp;
        logic       motor_up;
        logic       motor_on;
    } result_t;

    function automatic logic [POS_W-1:0] floor_pos(input logic [1:0] k, input cfg_t c);
        logic [POS_W:0] sp1;
        logic [POS_W:0] sum;
        sp1 = {3'b0, c.spacing};
        case (k)
            FLOOR_0: sum = {2'b0, c.floor0};
            FLOOR_1: sum = {2'b0, c.floor0} + sp1;
            FLOOR_2: sum = {2'b0, c.floor0} + (sp1 << 1);
            default: sum = {2'b0, c.floor0} + sp1 + (sp1 << 1);
        endcase
        return sum[POS_W-1:0];
    endfunction

    // open window: |s - pos| < tol
    function automatic logic in_window(input logic [SAMPLE_W-1:0] s,
                                       input logic [POS_W-1:0] pos,
                                       input logic [TOL_W-1:0] tol);
        logic signed [POS_W+1:0] d;
        logic signed [POS_W+1:0] t;
        d = $signed({3'b0, s}) - $signed({2'b0, pos});
        t = $signed({7'b0, tol});
        return (d < t) && (d > -t);
    endfunction

    function automatic logic [6:0] seg_of(input logic [1:0] f);
        case (f)
            FLOOR_0: return SEG_0;
            FLOOR_1: return SEG_1;
            FLOOR_2: return SEG_2;
            default: return 7'h00;
        endcase
    endfunction

endpackage

// ===== src/tfec_cfg.sv =====
// Configuration register file: floor base position, floor spacing, window tolerance.
module tfec_cfg
    import tfec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_FLOOR0:  cfg_next.floor0  = wr_data[F0_W-1:0];
                REG_SPACING: cfg_next.spacing = wr_data[SPACING_W-1:0];
                REG_TOL:     cfg_next.tol     = wr_data[TOL_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{floor0: F0_RST, spacing: SPACING_RST, tol: TOL_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tfec_core.sv =====
// Elevator state registers and the combinational decision logic for one request.
module tfec_core
    import tfec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [1:0]          action,
    input  logic [2:0]          key,
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    output result_t             result
);

    logic [1:0]       cur_floor_reg,  cur_floor_next;
    logic             moving_reg,     moving_next;
    logic             dir_up_reg,     dir_up_next;
    logic [1:0]       tgt_floor_reg,  tgt_floor_next;
    logic [POS_W-1:0] tgt_pos_reg,    tgt_pos_next;
    logic             q_valid_reg,    q_valid_next;
    logic [1:0]       q_floor_reg,    q_floor_next;
    logic             stop_lit_reg,   stop_lit_next;
    logic             buzzer_reg,     buzzer_next;

    logic [1:0] est_floor;
    logic       at_target;
    logic       rep, rep_em, rep_al;

    // last matching window wins in the order 1, 2, 0
    always_comb begin
        if (in_window(sample, floor_pos(FLOOR_0, cfg), cfg.tol)) begin
            est_floor = FLOOR_0;
        end else if (in_window(sample, floor_pos(FLOOR_2, cfg), cfg.tol)) begin
            est_floor = FLOOR_2;
        end else if (in_window(sample, floor_pos(FLOOR_1, cfg), cfg.tol)) begin
            est_floor = FLOOR_1;
        end else begin
            est_floor = cur_floor_reg;
        end
    end

    assign at_target = in_window(sample, tgt_pos_reg, cfg.tol);

    always_comb begin
        cur_floor_next = cur_floor_reg;
        moving_next    = moving_reg;
        dir_up_next    = dir_up_reg;
        tgt_floor_next = tgt_floor_reg;
        tgt_pos_next   = tgt_pos_reg;
        q_valid_next   = q_valid_reg;
        q_floor_next   = q_floor_reg;
        stop_lit_next  = stop_lit_reg;
        buzzer_next    = buzzer_reg;
        rep            = 1'b0;
        rep_em         = 1'b0;
        rep_al         = 1'b0;
        case (action)
            ACT_KEY: begin
                if (key inside {[KEY_FLOOR0:KEY_FLOOR2]}) begin
                    stop_lit_next = 1'b0;
                    if (!moving_reg) begin
                        tgt_floor_next = key[1:0];
                        tgt_pos_next   = floor_pos(key[1:0], cfg);
                        if (key[1:0] != cur_floor_reg) begin
                            dir_up_next = key[1:0] > cur_floor_reg;
                            moving_next = 1'b1;
                        end
                    end else if (!q_valid_reg && key[1:0] != tgt_floor_reg) begin
                        q_valid_next = 1'b1;
                        q_floor_next = key[1:0];
                    end
                end else if (key == KEY_ALARM) begin
                    buzzer_next = 1'b1;
                    rep_al      = 1'b1;
                end else if (key == KEY_ESTOP) begin
                    moving_next   = 1'b0;
                    stop_lit_next = 1'b1;
                    q_valid_next  = 1'b0;
                    rep_em        = 1'b1;
                end
            end
            ACT_SAMPLE: begin
                if (moving_reg) begin
                    if (at_target) begin
                        cur_floor_next = est_floor;
                        moving_next    = 1'b0;
                        if (q_valid_reg) begin
                            q_valid_next   = 1'b0;
                            tgt_floor_next = q_floor_reg;
                            tgt_pos_next   = floor_pos(q_floor_reg, cfg);
                            if (q_floor_reg != est_floor) begin
                                dir_up_next = q_floor_reg > est_floor;
                                moving_next = 1'b1;
                            end
                        end
                    end
                    if ({1'b0, sample} != tgt_pos_next) begin
                        cur_floor_next = est_floor;
                        rep            = 1'b1;
                    end
                end
            end
            ACT_TIMER: buzzer_next = 1'b0;
            default:   buzzer_next = buzzer_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_floor_reg <= FLOOR_0;
            moving_reg    <= 1'b0;
            dir_up_reg    <= 1'b0;
            tgt_floor_reg <= FLOOR_0;
            tgt_pos_reg   <= '0;
            q_valid_reg   <= 1'b0;
            q_floor_reg   <= FLOOR_0;
            stop_lit_reg  <= 1'b0;
            buzzer_reg    <= 1'b0;
        end else if (step) begin
            cur_floor_reg <= cur_floor_next;
            moving_reg    <= moving_next;
            dir_up_reg    <= dir_up_next;
            tgt_floor_reg <= tgt_floor_next;
            tgt_pos_reg   <= tgt_pos_next;
            q_valid_reg   <= q_valid_next;
            q_floor_reg   <= q_floor_next;
            stop_lit_reg  <= stop_lit_next;
            buzzer_reg    <= buzzer_next;
        end
    end

    always_comb begin
        result.motor_on         = moving_next;
        result.motor_up         = dir_up_next;
        result.stop_lamp        = stop_lit_next;
        result.buzzer           = buzzer_next;
        result.segments         = seg_of(cur_floor_next);
        result.report_valid     = rep;
        result.report_floor     = rep ? cur_floor_next : 2'd0;
        result.report_emergency = rep_em;
        result.report_alarm     = rep_al;
    end

endmodule

// ===== src/three_floor_elevator_controller.sv =====
// Top level: stream ports, input register, result register and configuration port.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_tvalid/s_tready | s_tuser action, s_tdata key and sample
//  m_      | out       | m_tvalid/m_tready | m_tdata lamps, motor, display, reports
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless m_tready stalls the output; a taken request goes into
// the input register, then through the decision logic into the result register.
// aresetn clears the elevator state, the valid flags and loads the register defaults.
// A stall on m_tready holds the result; s_tready drops only when both registers are full
// and m_tready is low.
// cfg_ready is always high.
module three_floor_elevator_controller
    import tfec_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [2:0] key, [14:3] sample, [15] zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] motor_on, [1] motor_up, [2] stop_lamp,
                                             // [3] buzzer, [10:4] segments,
                                             // [11] report_valid, [13:12] report_floor,
                                             // [14] report_emergency, [15] report_alarm
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SAMPLE_KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((32'd1 << SAMPLE_KEEP) - 32'd1);

    logic                in_vld_reg;
    logic [1:0]          action_reg;
    logic [2:0]          key_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_vld_reg;
    result_t             out_reg;

    cfg_t    cfg;
    result_t result;
    logic    advance;
    logic    s_accept;

    assign advance   = !out_vld_reg || m_tready;
    assign s_tready  = !in_vld_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tfec_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tfec_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_vld_reg && advance),
        .action  (action_reg),
        .key     (key_reg),
        .sample  (sample_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            action_reg <= s_tuser[1:0];
            key_reg    <= s_tdata[2:0];
            sample_reg <= s_tdata[3 +: SAMPLE_W] & SAMPLE_MASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule
